/* hw/rtl/mahp_pkg.sv */
// ----------------------------------------------------------------------------
// mahp_pkg
// Types, codes and rate tables shared by the frame header parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mahp_pkg;

  // sync pattern
  localparam logic [7:0] SYNC_FIRST      = 8'hFF;
  localparam logic [7:0] SYNC_SECOND_MIN = 8'hE0;

  // version codes
  localparam logic [1:0] VER_25       = 2'd0;
  localparam logic [1:0] VER_RESERVED = 2'd1;
  localparam logic [1:0] VER_2        = 2'd2;
  localparam logic [1:0] VER_1        = 2'd3;

  // layer codes
  localparam logic [1:0] LAYER_RESERVED = 2'd0;
  localparam logic [1:0] LAYER_3        = 2'd1;
  localparam logic [1:0] LAYER_2        = 2'd2;
  localparam logic [1:0] LAYER_1        = 2'd3;

  // channel mode for a stream with no header
  localparam logic [2:0] CH_MODE_UNKNOWN = 3'd4;

  // sync hunter phase
  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_WANT_THIRD,
    PH_WANT_FOURTH,
    PH_DONE
  } phase_t;

  // raw header record passed from front to back
  typedef struct packed {
    logic       found;
    logic [4:0] second_bits;
    logic [7:0] third_byte;
    logic [1:0] mode_bits;
  } hdr_rec_t;

  // bitrate tables in kbps
  localparam logic [8:0] RATE_V1_L3 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] RATE_V1_L2 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] RATE_V1_L1 [16] = '{
    9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
    9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] RATE_V2_L1 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] RATE_V2_L23 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  // sample rate tables in Hz
  localparam logic [15:0] SRATE_V1 [4]  = '{16'd44100, 16'd48000, 16'd32000, 16'd0};
  localparam logic [15:0] SRATE_V2 [4]  = '{16'd22050, 16'd24000, 16'd16000, 16'd0};
  localparam logic [15:0] SRATE_V25 [4] = '{16'd11025, 16'd12000, 16'd8000, 16'd0};

  // bitrate from version, layer and index; 0 for reserved codes
  function automatic logic [8:0] bitrate_lookup(input logic [1:0] ver,
                                                input logic [1:0] lay,
                                                input logic [3:0] idx);
    logic [8:0] br;
    br = 9'd0;
    unique case (ver)
      VER_1: begin
        unique case (lay)
          LAYER_3:        br = RATE_V1_L3[idx];
          LAYER_2:        br = RATE_V1_L2[idx];
          LAYER_1:        br = RATE_V1_L1[idx];
          default:        br = 9'd0;
        endcase
      end
      VER_2, VER_25: begin
        unique case (lay)
          LAYER_1:          br = RATE_V2_L1[idx];
          LAYER_2, LAYER_3: br = RATE_V2_L23[idx];
          default:          br = 9'd0;
        endcase
      end
      default: br = 9'd0;
    endcase
    return br;
  endfunction

  // sample rate from version and index; 0 for reserved codes
  function automatic logic [15:0] srate_lookup(input logic [1:0] ver,
                                               input logic [1:0] idx);
    logic [15:0] sr;
    sr = 16'd0;
    unique case (ver)
      VER_1:   sr = SRATE_V1[idx];
      VER_2:   sr = SRATE_V2[idx];
      VER_25:  sr = SRATE_V25[idx];
      default: sr = 16'd0;
    endcase
    return sr;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mahp_if.sv */
// ----------------------------------------------------------------------------
// mahp_if
// Valid/ready channels of the frame header parser: byte stream in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mahp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface mahp_result_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [1:0]  version_code;
  logic [1:0]  layer_code;
  logic        crc_bit;
  logic [8:0]  bitrate_kbps;
  logic [15:0] sample_rate_hz;
  logic [2:0]  channel_mode;

  modport source (output valid, output found, output version_code, output layer_code,
                  output crc_bit, output bitrate_kbps, output sample_rate_hz,
                  output channel_mode, input ready);
  modport sink   (input valid, input found, input version_code, input layer_code,
                  input crc_bit, input bitrate_kbps, input sample_rate_hz,
                  input channel_mode, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mahp_queue.sv */
// ----------------------------------------------------------------------------
// mahp_queue
// Short register queue of raw header records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mahp_queue
  import mahp_pkg::*;
#(
  parameter int Depth = 2
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire hdr_rec_t push_rec,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output hdr_rec_t      head_rec
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  hdr_rec_t            slots [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head_rec   = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mahp_sync_front.sv */
// ----------------------------------------------------------------------------
// mahp_sync_front
// Hunts for frame sync, gathers the header bytes and queues a raw record.
// ----------------------------------------------------------------------------
`default_nettype none

module mahp_sync_front
  import mahp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  mahp_byte_if.sink   stream,
  input  wire logic   queue_full,
  output logic        push,
  output hdr_rec_t    push_rec
);

  phase_t     phase, phase_next;
  logic       prev_was_ff, prev_was_ff_next;
  logic [4:0] saved_second, saved_second_next;
  logic [7:0] saved_third, saved_third_next;
  logic       accept;
  logic       emit_hdr;
  logic       emit_none;

  assign stream.ready = !queue_full;
  assign accept       = stream.valid && stream.ready;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SEARCH;
      prev_was_ff <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      prev_was_ff <= prev_was_ff_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      saved_second <= saved_second_next;
      saved_third  <= saved_third_next;
    end
  end

  // next state and record
  always_comb begin
    phase_next        = phase;
    prev_was_ff_next  = prev_was_ff;
    saved_second_next = saved_second;
    saved_third_next  = saved_third;
    emit_hdr          = 1'b0;
    emit_none         = 1'b0;
    unique case (phase)
      PH_SEARCH: begin
        if (prev_was_ff && stream.in_byte >= SYNC_SECOND_MIN) begin
          saved_second_next = stream.in_byte[4:0];
          prev_was_ff_next  = 1'b0;
          phase_next        = PH_WANT_THIRD;
        end else begin
          prev_was_ff_next = (stream.in_byte == SYNC_FIRST);
        end
      end
      PH_WANT_THIRD: begin
        saved_third_next = stream.in_byte;
        phase_next       = PH_WANT_FOURTH;
      end
      PH_WANT_FOURTH: begin
        emit_hdr   = 1'b1;
        phase_next = PH_DONE;
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_SEARCH;
      end
    endcase
    // last word: report a miss unless a header went out, then start over
    if (stream.end_of_stream) begin
      emit_none        = !emit_hdr && (phase_next != PH_DONE);
      phase_next       = PH_SEARCH;
      prev_was_ff_next = 1'b0;
    end
  end

  assign push                 = accept && (emit_hdr || emit_none);
  assign push_rec.found       = emit_hdr;
  assign push_rec.second_bits = saved_second;
  assign push_rec.third_byte  = saved_third;
  assign push_rec.mode_bits   = stream.in_byte[7:6];

endmodule

`default_nettype wire

/* hw/rtl/mahp_decode_back.sv */
// ----------------------------------------------------------------------------
// mahp_decode_back
// Decodes a raw header record through the rate tables into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mahp_decode_back
  import mahp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     head_valid,
  input  wire hdr_rec_t head_rec,
  output logic          pop,
  mahp_result_if.source result
);

  logic [1:0] ver;
  logic [1:0] lay;

  assign ver = head_rec.second_bits[4:3];
  assign lay = head_rec.second_bits[2:1];
  assign pop = head_valid && (!result.valid || result.ready);

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (pop) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (pop) begin
      if (head_rec.found) begin
        result.found          <= 1'b1;
        result.version_code   <= ver;
        result.layer_code     <= lay;
        result.crc_bit        <= head_rec.second_bits[0];
        result.bitrate_kbps   <= bitrate_lookup(ver, lay, head_rec.third_byte[7:4]);
        result.sample_rate_hz <= srate_lookup(ver, head_rec.third_byte[3:2]);
        result.channel_mode   <= {1'b0, head_rec.mode_bits};
      end else begin
        result.found          <= 1'b0;
        result.version_code   <= VER_RESERVED;
        result.layer_code     <= LAYER_RESERVED;
        result.crc_bit        <= 1'b1;
        result.bitrate_kbps   <= '0;
        result.sample_rate_hz <= '0;
        result.channel_mode   <= CH_MODE_UNKNOWN;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mpeg_audio_frame_header_parser_core.sv */
// ----------------------------------------------------------------------------
// mpeg_audio_frame_header_parser_core
// Finds the first audio frame header in a byte stream and decodes it.
//
//   channel   dir   payload                                        words
//   stream    in    in_byte, end_of_stream                         one byte
//   result    out   found, version_code, layer_code, crc_bit,      one per
//                   bitrate_kbps, sample_rate_hz, channel_mode     stream
//
// One byte is taken every cycle unless the record queue is full; a result
// is queued by the sync front, then table decoded into the output register.
// Reset clears the sync phase, the queue and the output valid.
// The front stalls only when the record queue is full; the queue fills only
// while the result sink holds ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module mpeg_audio_frame_header_parser_core
  import mahp_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  wire logic     clk,
  input  wire logic     rst,
  mahp_byte_if.sink     stream,
  mahp_result_if.source result
);

  logic     queue_full;
  logic     push;
  hdr_rec_t push_rec;
  logic     pop;
  logic     head_valid;
  hdr_rec_t head_rec;

  // sync hunt and header capture
  mahp_sync_front u_front (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .queue_full (queue_full),
    .push       (push),
    .push_rec   (push_rec)
  );

  // record queue
  mahp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  // table decode and output register
  mahp_decode_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .result     (result)
  );

endmodule

`default_nettype wire

/* tb/mahp_header_checker.sv */
// ----------------------------------------------------------------------------
// mahp_header_checker
// Watches the byte stream and result channels of the frame header parser,
// predicts the decoded header (or no-header result) of every stream and
// compares each result word, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module mahp_header_checker
  import mahp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  mahp_byte_if   stream,
  mahp_result_if result,
  output int     mismatches,
  output int     results_due,
  output int     results_seen,
  output int     headers_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        found;
    logic [1:0]  version;
    logic [1:0]  layer;
    logic        crc;
    logic [8:0]  kbps;
    logic [15:0] hz;
    logic [2:0]  mode;
  } hdr_result_t;

  localparam hdr_result_t NO_HEADER = '{
    found: 1'b0, version: VER_RESERVED, layer: LAYER_RESERVED, crc: 1'b1,
    kbps: 9'd0, hz: 16'd0, mode: CH_MODE_UNKNOWN};

  // bitrates in kbps, indexed by the top nibble of the third header byte
  localparam logic [8:0] KBPS_V1_L1 [16] = '{
    0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0};
  localparam logic [8:0] KBPS_V1_L2 [16] = '{
    0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0};
  localparam logic [8:0] KBPS_V1_L3 [16] = '{
    0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0};
  localparam logic [8:0] KBPS_V2_L1 [16] = '{
    0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0};
  localparam logic [8:0] KBPS_V2_L23 [16] = '{
    0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0};

  // sample rates in Hz
  localparam logic [15:0] HZ_V1 [4]  = '{44100, 48000, 32000, 0};
  localparam logic [15:0] HZ_V2 [4]  = '{22050, 24000, 16000, 0};
  localparam logic [15:0] HZ_V25 [4] = '{11025, 12000, 8000, 0};

  // sync hunter copy
  phase_t     hunt_phase;
  logic       prev_ff;
  logic [4:0] sec_bits;
  logic [7:0] third_byte;

  hdr_result_t headers_due[$];
  hdr_result_t got_result;
  int          err_count;
  int          seen_count;
  int          found_count;

  function automatic hdr_result_t decode_header(input logic [4:0] sec,
                                                input logic [7:0] third,
                                                input logic [7:0] fourth);
    hdr_result_t r;
    logic [3:0]  bidx;
    logic [1:0]  sidx;
    r.found   = 1'b1;
    r.version = sec[4:3];
    r.layer   = sec[2:1];
    r.crc     = sec[0];
    r.kbps    = 9'd0;
    r.hz      = 16'd0;
    r.mode    = {1'b0, fourth[7:6]};
    bidx      = third[7:4];
    sidx      = third[3:2];
    case (r.version)
      VER_1: begin
        r.hz = HZ_V1[sidx];
        case (r.layer)
          LAYER_1: r.kbps = KBPS_V1_L1[bidx];
          LAYER_2: r.kbps = KBPS_V1_L2[bidx];
          LAYER_3: r.kbps = KBPS_V1_L3[bidx];
          default: r.kbps = 9'd0;
        endcase
      end
      VER_2, VER_25: begin
        // mpeg 2.5 shares the mpeg 2 bitrate tables
        r.hz = (r.version == VER_25) ? HZ_V25[sidx] : HZ_V2[sidx];
        if (r.layer == LAYER_1) begin
          r.kbps = KBPS_V2_L1[bidx];
        end else if (r.layer != LAYER_RESERVED) begin
          r.kbps = KBPS_V2_L23[bidx];
        end
      end
      default: r.kbps = 9'd0;
    endcase
    return r;
  endfunction

  task automatic restart_hunt();
    hunt_phase = PH_SEARCH;
    prev_ff    = 1'b0;
    sec_bits   = '0;
    third_byte = '0;
  endtask

  // one accepted byte through the sync hunter
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic emitted;
    emitted = 1'b0;
    case (hunt_phase)
      PH_SEARCH: begin
        if (prev_ff && b >= SYNC_SECOND_MIN) begin
          sec_bits   = b[4:0];
          prev_ff    = 1'b0;
          hunt_phase = PH_WANT_THIRD;
        end else begin
          prev_ff = (b == SYNC_FIRST);
        end
      end
      PH_WANT_THIRD: begin
        third_byte = b;
        hunt_phase = PH_WANT_FOURTH;
      end
      PH_WANT_FOURTH: begin
        headers_due.push_back(decode_header(sec_bits, third_byte, b));
        emitted    = 1'b1;
        hunt_phase = PH_DONE;
      end
      default: ;
    endcase
    // last byte: no-header result unless a header went out already
    if (last) begin
      if (!emitted && hunt_phase != PH_DONE) begin
        headers_due.push_back(NO_HEADER);
      end
      restart_hunt();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  task automatic check_result(input hdr_result_t got);
    hdr_result_t want;
    if (headers_due.size() == 0) begin
      $display("%0t: result word with nothing expected, actual found %0d mode %0d",
               $time, got.found, got.mode);
      err_count++;
    end else begin
      want = headers_due.pop_front();
      check_field("found", want.found, got.found);
      check_field("version_code", want.version, got.version);
      check_field("layer_code", want.layer, got.layer);
      check_field("crc_bit", want.crc, got.crc);
      check_field("bitrate_kbps", want.kbps, got.kbps);
      check_field("sample_rate_hz", want.hz, got.hz);
      check_field("channel_mode", want.mode, got.mode);
    end
  endtask

  // compare outgoing words first, then predict from the incoming byte
  always @(posedge clk) begin
    if (rst) begin
      restart_hunt();
      headers_due.delete();
    end else begin
      if (result.valid && result.ready) begin
        got_result = '{found: result.found, version: result.version_code,
                       layer: result.layer_code, crc: result.crc_bit,
                       kbps: result.bitrate_kbps, hz: result.sample_rate_hz,
                       mode: result.channel_mode};
        check_result(got_result);
        seen_count++;
        if (result.found) begin
          found_count++;
        end
      end
      if (stream.valid && stream.ready) begin
        parse_byte(stream.in_byte, stream.end_of_stream);
      end
    end
    mismatches   <= err_count;
    results_due  <= headers_due.size();
    results_seen <= seen_count;
    headers_seen <= found_count;
  end

endmodule

/* tb/mpeg_audio_frame_header_parser_core_test.sv */
// ----------------------------------------------------------------------------
// mpeg_audio_frame_header_parser_core_test
// Drives byte streams into the frame header parser: a directed set of corner
// streams, then random streams through phases of sender idling and receiver
// stalling, a long receiver hold-off and a drain pause. Checking is done by
// mahp_header_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_header_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mahp_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 10;

  // corner streams: header then trailing byte, lone last byte, header on the
  // last byte with reserved layer, reserved version, short header, sync on the
  // last byte, near-miss sync bytes before a real one
  localparam int DIRECTED_LEN = 25;
  localparam logic [7:0] DIRECTED_BYTES [DIRECTED_LEN] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
    8'h00,
    8'hFF, 8'hE0, 8'h00, 8'h00,
    8'hFF, 8'hEA, 8'h90, 8'h40,
    8'hFF, 8'hF3, 8'h55,
    8'hFF, 8'hFB,
    8'hFE, 8'hDF, 8'hFF, 8'hFB, 8'h94, 8'hC4};
  localparam logic DIRECTED_LAST [DIRECTED_LEN] = '{
    0, 0, 0, 0, 1,
    1,
    0, 0, 0, 1,
    0, 0, 0, 1,
    0, 0, 1,
    0, 1,
    0, 0, 0, 0, 0, 1};

  typedef logic [7:0] byte_q_t[$];

  logic clk = 1'b0;
  logic rst = 1'b1;

  mahp_byte_if   byte_ch ();
  mahp_result_if result_ch ();

  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;
  int hold_asked      = 0;
  int hold_served     = 0;
  int bytes_sent      = 0;
  int streams_sent    = 0;
  int stuck_cycles    = 0;

  int mismatches;
  int results_due;
  int results_seen;
  int headers_seen;

  always #(CLK_PERIOD / 2) clk = ~clk;

  mpeg_audio_frame_header_parser_core uut (
    .clk    (clk),
    .rst    (rst),
    .stream (byte_ch),
    .result (result_ch)
  );

  mahp_header_checker chk (
    .clk          (clk),
    .rst          (rst),
    .stream       (byte_ch),
    .result       (result_ch),
    .mismatches   (mismatches),
    .results_due  (results_due),
    .results_seen (results_seen),
    .headers_seen (headers_seen)
  );

  // bytes biased toward sync candidates
  function automatic logic [7:0] noise_byte();
    int pick;
    pick = $urandom_range(9);
    if (pick < 2) begin
      return SYNC_FIRST;
    end else if (pick == 2) begin
      return 8'($urandom_range(255, SYNC_SECOND_MIN));
    end
    return 8'($urandom_range(255));
  endfunction

  // mostly full headers with random content, some cut short, some pure noise
  function automatic byte_q_t random_stream();
    byte_q_t s;
    int      kind;
    int      cut;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      repeat ($urandom_range(8, 1)) s.push_back(noise_byte());
    end else begin
      repeat ($urandom_range(3)) s.push_back(noise_byte());
      s.push_back(SYNC_FIRST);
      s.push_back(SYNC_SECOND_MIN | 8'($urandom_range(31)));
      if (kind < 70) begin
        s.push_back(8'($urandom));
        s.push_back(8'($urandom));
        repeat ($urandom_range(3)) s.push_back(8'($urandom));
      end else begin
        cut = $urandom_range(2);
        if (cut == 0) begin
          void'(s.pop_back());
        end else if (cut == 2) begin
          s.push_back(8'($urandom));
        end
      end
    end
    return s;
  endfunction

  task automatic push_word(input logic [7:0] b, input logic last);
    logic took;
    while ($urandom_range(99) < sender_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.in_byte       <= b;
    byte_ch.end_of_stream <= last;
    // ready is settled by the falling edge
    do begin
      @(negedge clk);
      took = byte_ch.ready;
      @(posedge clk);
    end while (!took);
    bytes_sent++;
    if (last) begin
      streams_sent++;
    end
  endtask

  task automatic send_stream(input byte_q_t s);
    foreach (s[i]) begin
      push_word(s[i], i == s.size() - 1);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int budget);
    int start;
    start           = bytes_sent;
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    while (bytes_sent - start < budget) begin
      send_stream(random_stream());
    end
  endtask

  task automatic wait_for_results();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) begin
      @(posedge clk);
    end
  endtask

  // stream sender
  initial begin
    byte_ch.valid         <= 1'b0;
    byte_ch.in_byte       <= '0;
    byte_ch.end_of_stream <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      push_word(DIRECTED_BYTES[i], DIRECTED_LAST[i]);
    end

    run_phase(0, 0, 100);
    run_phase(88, 0, 70);
    run_phase(0, 88, 90);
    run_phase(32, 32, 90);

    // long receiver hold-off while bytes keep coming, then drain
    hold_asked++;
    run_phase(0, 0, 60);
    wait_for_results();
    run_phase(32, 32, 30);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d bytes in %0d streams", bytes_sent, streams_sent);
    $display("%0d result words checked, %0d with a decoded header",
             results_seen, headers_seen);
    if (mismatches == 0 && results_due == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result receiver: random stalls, plus the long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_asked != hold_served) begin
        hold_left = HOLD_CYCLES;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

/* sim.f */
hw/rtl/mahp_pkg.sv
hw/rtl/mahp_if.sv
hw/rtl/mahp_queue.sv
hw/rtl/mahp_sync_front.sv
hw/rtl/mahp_decode_back.sv
hw/rtl/mpeg_audio_frame_header_parser_core.sv
tb/mahp_header_checker.sv
tb/mpeg_audio_frame_header_parser_core_test.sv
